>>> design/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared widths, register map, reset values and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int DATA_W  = 64;
    localparam int RATIO_W = 32;
    localparam int THR_W   = 20;
    localparam int PREC_W  = 20;
    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;
    localparam int CNT_W   = $clog2(DATA_W);

    localparam int TICKS_PER_US_DEF = 1000;

    localparam logic [RATIO_W-1:0] FREQ_RATIO_RST   = RATIO_W'(32'h0001_0000);
    localparam logic [THR_W-1:0]   THRESHOLD_RST    = '0;
    localparam logic [PREC_W-1:0]  PRECISION_RST    = '0;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_FREQ_RATIO = 2'd0;
    localparam logic [1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_PRECISION  = 2'd2;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_DELAY  = 1'b1;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic combine;
        logic div_init;
        logic div_step;
        logic rnd_sub;
        logic rnd_add;
        logic accum;
        logic update;
        logic backlog;
        logic result;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic prec_on;
        logic out_free;
    } t_dp_sts;

endpackage

>>> design/cda_in_if.sv
// ----------------------------------------------------------------------------
// cda_in_if
// Input channel: valid/ready handshake carrying one delay or time word.
// ----------------------------------------------------------------------------
interface cda_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] time_value;

    modport source (output valid, output func, output time_value, input ready);
    modport sink   (input valid, input func, input time_value, output ready);
endinterface

>>> design/cda_out_if.sv
// ----------------------------------------------------------------------------
// cda_out_if
// Output channel: valid/ready handshake carrying the backlog report.
// ----------------------------------------------------------------------------
interface cda_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] pending_delay;
    logic        blocked;

    modport source (output valid, output pending_delay, output blocked, input ready);
    modport sink   (input valid, input pending_delay, input blocked, output ready);
endinterface

>>> design/cda_regs.sv
// ----------------------------------------------------------------------------
// cda_regs
// APB register file: frequency ratio, blocking threshold and rounding
// precision.
// ----------------------------------------------------------------------------
module cda_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cda_pkg::ADDR_W-1:0]  paddr,
    input  logic [cda_pkg::APB_W-1:0]   pwdata,
    output logic [cda_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    output logic [cda_pkg::RATIO_W-1:0] o_freq_ratio,
    output logic [cda_pkg::THR_W-1:0]   o_threshold_us,
    output logic [cda_pkg::PREC_W-1:0]  o_precision_us
);

    logic [cda_pkg::RATIO_W-1:0] r_freq_ratio;
    logic [cda_pkg::THR_W-1:0]   r_threshold_us;
    logic [cda_pkg::PREC_W-1:0]  r_precision_us;
    logic [1:0]                  w_index;
    logic                        w_write;

    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_ratio   <= cda_pkg::FREQ_RATIO_RST;
            r_threshold_us <= cda_pkg::THRESHOLD_RST;
            r_precision_us <= cda_pkg::PRECISION_RST;
        end else if (w_write) begin
            case (w_index)
                cda_pkg::REG_FREQ_RATIO: r_freq_ratio   <= pwdata[cda_pkg::RATIO_W-1:0];
                cda_pkg::REG_THRESHOLD:  r_threshold_us <= pwdata[cda_pkg::THR_W-1:0];
                cda_pkg::REG_PRECISION:  r_precision_us <= pwdata[cda_pkg::PREC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            cda_pkg::REG_FREQ_RATIO: prdata = r_freq_ratio;
            cda_pkg::REG_THRESHOLD:  prdata = cda_pkg::APB_W'(r_threshold_us);
            cda_pkg::REG_PRECISION:  prdata = cda_pkg::APB_W'(r_precision_us);
            default:                 prdata = '0;
        endcase
    end

    assign o_freq_ratio   = r_freq_ratio;
    assign o_threshold_us = r_threshold_us;
    assign o_precision_us = r_precision_us;

endmodule

>>> design/cda_dp.sv
// ----------------------------------------------------------------------------
// cda_dp
// Datapath: shared 32x32 multiplier for the ratio scaling, bit-serial
// remainder unit for rounding, time accumulators and the result register.
// ----------------------------------------------------------------------------
module cda_dp #(
    parameter int TICKS_PER_US = cda_pkg::TICKS_PER_US_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cda_pkg::t_dp_cmd            i_cmd,
    output cda_pkg::t_dp_sts            o_sts,
    input  logic                        i_in_func,
    input  logic [cda_pkg::DATA_W-1:0]  i_in_time,
    input  logic [cda_pkg::RATIO_W-1:0] i_freq_ratio,
    input  logic [cda_pkg::THR_W-1:0]   i_threshold_us,
    input  logic [cda_pkg::PREC_W-1:0]  i_precision_us,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cda_pkg::DATA_W-1:0]  o_pending_delay,
    output logic                        o_blocked
);

    localparam int DW    = cda_pkg::DATA_W;
    localparam int HW    = DW / 2;
    localparam int TPU_W = $clog2(TICKS_PER_US + 1);
    localparam int GW    = cda_pkg::PREC_W + TPU_W;
    localparam int TW    = cda_pkg::THR_W + TPU_W;
    localparam int SHIFT = 16;

    logic          r_func;
    logic [DW-1:0] r_tv;
    logic [GW-1:0] r_gran;
    logic [TW-1:0] r_thr;
    logic [DW-1:0] r_lo;
    logic [DW-1:0] r_hi;
    logic [DW-1:0] r_adj;
    logic [DW-1:0] r_shift;
    logic [GW:0]   r_rem;
    logic          r_up;
    logic [DW-1:0] r_cur;
    logic [DW-1:0] r_free;
    logic [DW-1:0] r_backlog;
    logic          r_out_valid;
    logic [DW-1:0] r_pending;
    logic          r_blocked;

    logic [HW-1:0] w_mul_a;
    logic [DW-1:0] w_prod;
    logic [DW:0]   w_comb_sum;
    logic [GW:0]   w_rem_try;
    logic [DW:0]   w_rnd_sum;
    logic [DW:0]   w_acc_sum;
    logic          w_over;

    // shared multiplier, one half of the delay per cycle
    assign w_mul_a = i_cmd.mul_hi ? r_tv[DW-1:HW] : r_tv[HW-1:0];
    assign w_prod  = DW'(w_mul_a) * DW'(i_freq_ratio);

    assign w_comb_sum = {1'b0, r_hi[DW-SHIFT-1:0], {SHIFT{1'b0}}}
                      + {{(SHIFT+1){1'b0}}, r_lo[DW-1:SHIFT]};
    assign w_rem_try  = {r_rem[GW-1:0], r_shift[DW-1]};
    assign w_rnd_sum  = {1'b0, r_adj} + (DW+1)'(r_gran);
    assign w_acc_sum  = {1'b0, r_free} + {1'b0, r_adj};
    assign w_over     = (r_thr != '0) && (r_backlog > DW'(r_thr));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in_func;
            r_tv   <= i_in_time;
            r_gran <= GW'(i_precision_us) * GW'(TICKS_PER_US);
            r_thr  <= TW'(i_threshold_us) * TW'(TICKS_PER_US);
        end
        if (i_cmd.mul_lo) begin
            r_lo <= w_prod;
        end
        if (i_cmd.mul_hi) begin
            r_hi <= w_prod;
        end
        if (i_cmd.combine) begin
            if (r_hi[DW-1:DW-SHIFT] != '0 || w_comb_sum[DW]) begin
                r_adj <= '1;
            end else begin
                r_adj <= w_comb_sum[DW-1:0];
            end
        end
        if (i_cmd.div_init) begin
            r_rem   <= '0;
            r_shift <= r_adj;
        end
        if (i_cmd.div_step) begin
            r_shift <= {r_shift[DW-2:0], 1'b0};
            if (w_rem_try >= {1'b0, r_gran}) begin
                r_rem <= w_rem_try - {1'b0, r_gran};
            end else begin
                r_rem <= w_rem_try;
            end
        end
        if (i_cmd.rnd_sub) begin
            r_adj <= r_adj - DW'(r_rem[GW-1:0]);
            r_up  <= {r_rem[GW-1:0], 1'b0} >= {1'b0, r_gran};
        end
        if (i_cmd.rnd_add && r_up) begin
            r_adj <= w_rnd_sum[DW] ? '1 : w_rnd_sum[DW-1:0];
        end
        if (i_cmd.backlog) begin
            r_backlog <= r_free - r_cur;
        end
        if (i_cmd.result) begin
            r_pending <= w_over ? r_backlog : '0;
            r_blocked <= w_over;
        end
    end

    // time state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_cur <= r_tv;
                if (r_free < r_tv) begin
                    r_free <= r_tv;
                end
            end
            if (i_cmd.accum) begin
                r_free <= w_acc_sum[DW] ? '1 : w_acc_sum[DW-1:0];
            end
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.func     = r_func;
    assign o_sts.prec_on  = (r_gran != '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_pending_delay = r_pending;
    assign o_blocked       = r_blocked;

endmodule

>>> design/cda_ctrl.sv
// ----------------------------------------------------------------------------
// cda_ctrl
// Controller: sequences load, scaling, rounding division, accumulation or time
// update and the backlog report for one word at a time.
// ----------------------------------------------------------------------------
module cda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cda_pkg::t_dp_sts i_sts,
    output cda_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MUL_LO,
        S_MUL_HI,
        S_COMBINE,
        S_DIV_INIT,
        S_DIV,
        S_RND_SUB,
        S_RND_ADD,
        S_ACCUM,
        S_UPDATE,
        S_BACKLOG,
        S_RESULT
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [cda_pkg::CNT_W-1:0] r_cnt;
    logic [cda_pkg::CNT_W-1:0] n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_state = (i_sts.func == cda_pkg::FUNC_DELAY) ? S_MUL_LO : S_UPDATE;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_COMBINE;
            end
            S_COMBINE: begin
                o_cmd.combine = 1'b1;
                n_state       = i_sts.prec_on ? S_DIV_INIT : S_ACCUM;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == cda_pkg::CNT_W'(cda_pkg::DATA_W - 1)) begin
                    n_state = S_RND_SUB;
                end
            end
            S_RND_SUB: begin
                o_cmd.rnd_sub = 1'b1;
                n_state       = S_RND_ADD;
            end
            S_RND_ADD: begin
                o_cmd.rnd_add = 1'b1;
                n_state       = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = S_BACKLOG;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_BACKLOG;
            end
            S_BACKLOG: begin
                o_cmd.backlog = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> design/cpu_delay_accumulator.sv
// A time update passes through start, update, backlog and result; an add-delay through
// start, both multiply halves, combine, accumulate, backlog and result, with rounding on
// also divide init, the bit-serial remainder unit and rounding subtract and add. One
// word at a time: the next word is accepted the cycle after the result is loaded, while
// that result may still wait at the output register.
// Reset: synchronous active-low; clears current and free time, registers to defaults.
// ----------------------------------------------------------------------------
// cpu_delay_accumulator
// Tracks virtual CPU busy time: scales and rounds delays, accumulates the
// free time with saturation and reports the backlog above a threshold.
// ----------------------------------------------------------------------------
module cpu_delay_accumulator #(
    parameter int TICKS_PER_US = cda_pkg::TICKS_PER_US_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cda_in_if.sink                     i_in_ch,
    cda_out_if.source                  o_out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cda_pkg::ADDR_W-1:0] paddr,
    input  logic [cda_pkg::APB_W-1:0]  pwdata,
    output logic [cda_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);

    logic [cda_pkg::RATIO_W-1:0] w_freq_ratio;
    logic [cda_pkg::THR_W-1:0]   w_threshold_us;
    logic [cda_pkg::PREC_W-1:0]  w_precision_us;
    cda_pkg::t_dp_cmd            w_cmd;
    cda_pkg::t_dp_sts            w_sts;
    logic                        w_in_ready;

    cda_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_freq_ratio   (w_freq_ratio),
        .o_threshold_us (w_threshold_us),
        .o_precision_us (w_precision_us)
    );

    cda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cda_dp #(
        .TICKS_PER_US (TICKS_PER_US)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_in_func       (i_in_ch.func),
        .i_in_time       (i_in_ch.time_value),
        .i_freq_ratio    (w_freq_ratio),
        .i_threshold_us  (w_threshold_us),
        .i_precision_us  (w_precision_us),
        .o_out_valid     (o_out_ch.valid),
        .i_out_ready     (o_out_ch.ready),
        .o_pending_delay (o_out_ch.pending_delay),
        .o_blocked       (o_out_ch.blocked)
    );

    assign i_in_ch.ready = w_in_ready;

endmodule
